@@ design/tree_lca_distance_engine_defines.svh @@
// Assertion macros shared by the tree distance engine.
`ifndef TREE_LCA_DISTANCE_ENGINE_DEFINES_SVH
`define TREE_LCA_DISTANCE_ENGINE_DEFINES_SVH
`ifndef ASSERT_OFF
`define TLDE_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define TLDE_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TLDE_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define TLDE_ASSERT(lbl, clk, prop, msg)
`endif
`endif

@@ design/tlde_pkg.sv @@
// Shared types and constants of the tree distance engine.
`default_nettype none
package tlde_pkg;

    localparam int DIST_W = 48;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_ERR_FULL,
        OP_ERR_RANGE,
        OP_ADD_RD,
        OP_ADD_WR,
        OP_FILL_RD,
        OP_FILL_WR,
        OP_ADD_DONE,
        OP_Q_RDA,
        OP_Q_RDB,
        OP_Q_ORDER,
        OP_LIFT_STEP,
        OP_LIFT_RD,
        OP_LIFT_WR,
        OP_CMP_SAME,
        OP_CMP_INIT,
        OP_JP_RD,
        OP_JQ_RD,
        OP_J_STEP,
        OP_DL_RD,
        OP_DL_SUM,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       add_full;
        logic       add_bad;
        logic       query_bad;
        logic       diff_zero;
        logic       lift_take;
        logic       pq_equal;
        logic       j_done;
        logic       fill_last;
        logic       single_level;
        logic       out_free;
    } dp_status_t;

endpackage
`default_nettype wire

@@ design/tlde_ctrl.sv @@
// Sequencer of the tree distance engine: walks the steps of each command.
`default_nettype none
module tlde_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire tlde_pkg::dp_status_t  status,
    output tlde_pkg::ctrl_cmd_t        cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_AR, S_AW, S_FR, S_FW, S_ADONE,
        S_QA, S_QB, S_QC, S_LIFT, S_LIFTW, S_JP, S_JQ, S_JC,
        S_DL, S_DC, S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = tlde_pkg::OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.op     = tlde_pkg::OP_LOAD;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                state_next = S_OUT;
                case (status.cmd)
                    tlde_pkg::CMD_START: cmd.op = tlde_pkg::OP_START;
                    tlde_pkg::CMD_ADD: begin
                        if (status.add_full) begin
                            cmd.op = tlde_pkg::OP_ERR_FULL;
                        end else if (status.add_bad) begin
                            cmd.op = tlde_pkg::OP_ERR_RANGE;
                        end else begin
                            state_next = S_AR;
                        end
                    end
                    tlde_pkg::CMD_QUERY: begin
                        if (status.query_bad) begin
                            cmd.op = tlde_pkg::OP_ERR_RANGE;
                        end else begin
                            state_next = S_QA;
                        end
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_AR: begin
                cmd.op     = tlde_pkg::OP_ADD_RD;
                state_next = S_AW;
            end
            S_AW: begin
                cmd.op     = tlde_pkg::OP_ADD_WR;
                state_next = status.single_level ? S_ADONE : S_FR;
            end
            S_FR: begin
                cmd.op     = tlde_pkg::OP_FILL_RD;
                state_next = S_FW;
            end
            S_FW: begin
                cmd.op     = tlde_pkg::OP_FILL_WR;
                state_next = status.fill_last ? S_ADONE : S_FR;
            end
            S_ADONE: begin
                cmd.op     = tlde_pkg::OP_ADD_DONE;
                state_next = S_OUT;
            end
            S_QA: begin
                cmd.op     = tlde_pkg::OP_Q_RDA;
                state_next = S_QB;
            end
            S_QB: begin
                cmd.op     = tlde_pkg::OP_Q_RDB;
                state_next = S_QC;
            end
            S_QC: begin
                cmd.op     = tlde_pkg::OP_Q_ORDER;
                state_next = S_LIFT;
            end
            S_LIFT: begin
                if (status.diff_zero) begin
                    if (status.pq_equal) begin
                        cmd.op     = tlde_pkg::OP_CMP_SAME;
                        state_next = S_DL;
                    end else begin
                        cmd.op     = tlde_pkg::OP_CMP_INIT;
                        state_next = S_JP;
                    end
                end else if (status.lift_take) begin
                    cmd.op     = tlde_pkg::OP_LIFT_RD;
                    state_next = S_LIFTW;
                end else begin
                    cmd.op = tlde_pkg::OP_LIFT_STEP;
                end
            end
            S_LIFTW: begin
                cmd.op     = tlde_pkg::OP_LIFT_WR;
                state_next = S_LIFT;
            end
            S_JP: begin
                cmd.op     = tlde_pkg::OP_JP_RD;
                state_next = S_JQ;
            end
            S_JQ: begin
                cmd.op     = tlde_pkg::OP_JQ_RD;
                state_next = S_JC;
            end
            S_JC: begin
                cmd.op     = tlde_pkg::OP_J_STEP;
                state_next = status.j_done ? S_DL : S_JP;
            end
            S_DL: begin
                cmd.op     = tlde_pkg::OP_DL_RD;
                state_next = S_DC;
            end
            S_DC: begin
                cmd.op     = tlde_pkg::OP_DL_SUM;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.op     = tlde_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ design/tlde_dp.sv @@
// Datapath of the tree distance engine: node and jump memories, walk registers, result register.
`default_nettype none
module tlde_dp #(
    parameter int MAX_NODES   = 65536,
    parameter int JUMP_LEVELS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire tlde_pkg::ctrl_cmd_t   cmd,
    output tlde_pkg::dp_status_t       status,
    input  wire logic [63:0]           s_tdata,
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [63:0]                m_tdata,
    output logic [1:0]                 m_tuser
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int LW   = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
    localparam int CW   = (NW + 1 > 16) ? NW + 1 : 17;
    localparam int DW   = tlde_pkg::DIST_W;
    localparam int NMW  = NW + DW;
    localparam int JAW  = NW + LW;
    localparam logic [LW-1:0] TOP = LW'(JUMP_LEVELS - 1);

    // node memory entry: depth in the upper bits, root distance below
    logic [NMW-1:0] node_mem [0:(2**NW)-1];
    logic [NW-1:0]  jump_mem [0:(2**JAW)-1];

    logic           node_we, node_re, jump_we, jump_re;
    logic [NW-1:0]  node_waddr, node_raddr;
    logic [NMW-1:0] node_wdata;
    logic [JAW-1:0] jump_waddr, jump_raddr;
    logic [NW-1:0]  jump_wdata;
    logic [NMW-1:0] node_rdata_reg;
    logic           node_rzero_reg;
    logic [NW-1:0]  jump_rdata_reg;
    logic           jump_rzero_reg;

    logic [1:0]     cmd_reg;
    logic [15:0]    a_reg, b_reg;
    logic [31:0]    len_reg;
    logic [NW:0]    count_reg;
    logic [NW-1:0]  p_reg, q_reg, cur_reg, jp_reg, lca_reg;
    logic [NW-1:0]  da_reg, diff_reg;
    logic [DW-1:0]  dista_reg, distb_reg;
    logic [LW-1:0]  lv_reg, j_reg;
    logic [DW-1:0]  res_path_reg;
    logic [NW-1:0]  res_anc_reg;
    logic [1:0]     res_st_reg;
    logic           m_valid_reg;
    logic [DW-1:0]  m_path_reg;
    logic [15:0]    m_anc_reg;
    logic [1:0]     m_st_reg;

    logic [CW-1:0]  a_ext, b_ext, cnt_ext, anc_ext;
    logic [NW-1:0]  a_idx, b_idx, v_idx;
    logic [NW-1:0]  nd_depth, jd;
    logic [DW-1:0]  nd_dist, new_dist;
    logic [DW:0]    add_sum, path_sum;

    assign a_ext   = CW'(a_reg);
    assign b_ext   = CW'(b_reg);
    assign cnt_ext = CW'(count_reg);
    assign a_idx   = a_ext[NW-1:0];
    assign b_idx   = b_ext[NW-1:0];
    assign v_idx   = count_reg[NW-1:0];
    assign anc_ext = CW'(res_anc_reg);

    // node 0 is the root: its entries always read as zero
    assign nd_depth = node_rzero_reg ? '0 : node_rdata_reg[NMW-1:DW];
    assign nd_dist  = node_rzero_reg ? '0 : node_rdata_reg[DW-1:0];
    assign jd       = jump_rzero_reg ? '0 : jump_rdata_reg;

    assign add_sum  = {1'b0, nd_dist} + (DW+1)'(len_reg);
    assign new_dist = add_sum[DW] ? tlde_pkg::DIST_MAX : add_sum[DW-1:0];
    assign path_sum = (DW+1)'(dista_reg - nd_dist) + (DW+1)'(distb_reg - nd_dist);

    always_comb begin
        status.cmd          = cmd_reg;
        status.add_full     = (count_reg >= (NW+1)'(MAX_NODES));
        status.add_bad      = (a_ext >= cnt_ext);
        status.query_bad    = (a_ext >= cnt_ext) || (b_ext >= cnt_ext);
        status.diff_zero    = (diff_reg == '0);
        status.lift_take    = ((diff_reg >> lv_reg) != '0);
        status.pq_equal     = (p_reg == q_reg);
        status.j_done       = (jp_reg == jd) && (lv_reg == '0);
        status.fill_last    = (j_reg == TOP);
        status.single_level = (JUMP_LEVELS == 1);
        status.out_free     = !m_valid_reg || m_tready;
    end

    always_comb begin
        node_we    = 1'b0;
        node_re    = 1'b0;
        jump_we    = 1'b0;
        jump_re    = 1'b0;
        node_waddr = v_idx;
        node_wdata = {nd_depth + NW'(1), new_dist};
        node_raddr = a_idx;
        jump_waddr = {v_idx, j_reg};
        jump_wdata = jd;
        jump_raddr = {p_reg, lv_reg};
        case (cmd.op)
            tlde_pkg::OP_ADD_RD, tlde_pkg::OP_Q_RDA: node_re = 1'b1;
            tlde_pkg::OP_Q_RDB: begin
                node_re    = 1'b1;
                node_raddr = b_idx;
            end
            tlde_pkg::OP_DL_RD: begin
                node_re    = 1'b1;
                node_raddr = lca_reg;
            end
            tlde_pkg::OP_ADD_WR: begin
                node_we    = 1'b1;
                jump_we    = 1'b1;
                jump_waddr = {v_idx, LW'(0)};
                jump_wdata = a_idx;
            end
            tlde_pkg::OP_FILL_RD: begin
                jump_re    = 1'b1;
                jump_raddr = {cur_reg, j_reg - LW'(1)};
            end
            tlde_pkg::OP_FILL_WR: jump_we = 1'b1;
            tlde_pkg::OP_LIFT_RD, tlde_pkg::OP_JP_RD: jump_re = 1'b1;
            tlde_pkg::OP_JQ_RD: begin
                jump_re    = 1'b1;
                jump_raddr = {q_reg, lv_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re) begin
            node_rdata_reg <= node_mem[node_raddr];
            node_rzero_reg <= (node_raddr == '0);
        end
        if (jump_we) begin
            jump_mem[jump_waddr] <= jump_wdata;
        end
        if (jump_re) begin
            jump_rdata_reg <= jump_mem[jump_raddr];
            jump_rzero_reg <= (jump_raddr[JAW-1:LW] == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= (NW+1)'(1);
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == tlde_pkg::OP_EMIT) begin
                m_valid_reg <= 1'b1;
                m_path_reg  <= res_path_reg;
                m_anc_reg   <= anc_ext[15:0];
                m_st_reg    <= res_st_reg;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.op)
                tlde_pkg::OP_LOAD: begin
                    cmd_reg      <= s_tuser;
                    a_reg        <= s_tdata[15:0];
                    b_reg        <= s_tdata[31:16];
                    len_reg      <= s_tdata[63:32];
                    res_path_reg <= '0;
                    res_anc_reg  <= '0;
                    res_st_reg   <= tlde_pkg::ST_OK;
                end
                tlde_pkg::OP_START:     count_reg  <= (NW+1)'(1);
                tlde_pkg::OP_ERR_FULL:  res_st_reg <= tlde_pkg::ST_FULL;
                tlde_pkg::OP_ERR_RANGE: res_st_reg <= tlde_pkg::ST_RANGE;
                tlde_pkg::OP_ADD_WR: begin
                    cur_reg <= a_idx;
                    j_reg   <= LW'(1);
                end
                tlde_pkg::OP_FILL_WR: begin
                    cur_reg <= jd;
                    j_reg   <= j_reg + LW'(1);
                end
                tlde_pkg::OP_ADD_DONE: begin
                    count_reg   <= count_reg + (NW+1)'(1);
                    res_anc_reg <= v_idx;
                end
                tlde_pkg::OP_Q_RDB: begin
                    da_reg    <= nd_depth;
                    dista_reg <= nd_dist;
                end
                tlde_pkg::OP_Q_ORDER: begin
                    distb_reg <= nd_dist;
                    lv_reg    <= TOP;
                    if (da_reg < nd_depth) begin
                        p_reg    <= b_idx;
                        q_reg    <= a_idx;
                        diff_reg <= nd_depth - da_reg;
                    end else begin
                        p_reg    <= a_idx;
                        q_reg    <= b_idx;
                        diff_reg <= da_reg - nd_depth;
                    end
                end
                tlde_pkg::OP_LIFT_STEP: lv_reg <= lv_reg - LW'(1);
                tlde_pkg::OP_LIFT_WR: begin
                    p_reg    <= jd;
                    diff_reg <= diff_reg - (NW'(1) << lv_reg);
                end
                tlde_pkg::OP_CMP_SAME: lca_reg <= p_reg;
                tlde_pkg::OP_CMP_INIT: lv_reg  <= TOP;
                tlde_pkg::OP_JQ_RD:    jp_reg  <= jd;
                tlde_pkg::OP_J_STEP: begin
                    if (jp_reg != jd) begin
                        p_reg <= jp_reg;
                        q_reg <= jd;
                        // top level repeats while apart; level 0 repeats until parents meet
                        if (lv_reg != TOP && lv_reg != '0) begin
                            lv_reg <= lv_reg - LW'(1);
                        end
                    end else if (lv_reg == '0) begin
                        lca_reg <= jp_reg;
                    end else begin
                        lv_reg <= lv_reg - LW'(1);
                    end
                end
                tlde_pkg::OP_DL_SUM: begin
                    res_path_reg <= path_sum[DW] ? tlde_pkg::DIST_MAX : path_sum[DW-1:0];
                    res_anc_reg  <= lca_reg;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_anc_reg, m_path_reg};
    assign m_tuser  = m_st_reg;

endmodule
`default_nettype wire

@@ design/tree_lca_distance_engine.sv @@
// Top level of the tree distance engine: sequencer plus datapath.
//  channel | dir | tdata (low bit up)                              | tuser
//  s_      | in  | first_node 16, second_node 16, edge_length 32   | command 2
//  m_      | out | path_length 48, common_ancestor 16              | status 2
// One item at a time; the next is taken once the result is in the output register.
// Start, errors and unused commands go from decode straight to the output step. An add
// reads the parent and writes the node, then does one jump-memory read and write per
// level above 0. A query reads both nodes, then has skipped lifting levels, lifting jumps
// and joint steps, each bound by one memory read port.
// Reset is synchronous and leaves a lone root; no memory clearing pass.
// A stalled result holds the block in its final step until taken.
`default_nettype none
`include "tree_lca_distance_engine_defines.svh"
module tree_lca_distance_engine #(
    parameter int MAX_NODES   = 65536,
    parameter int JUMP_LEVELS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // first_node, second_node, edge_length
    input  wire logic [1:0]  s_tuser,  // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,  // path_length, common_ancestor
    output logic [1:0]       m_tuser   // status
);

    tlde_pkg::ctrl_cmd_t  cmd;
    tlde_pkg::dp_status_t status;
    logic                 m_err;

    tlde_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tlde_dp #(
        .MAX_NODES   (MAX_NODES),
        .JUMP_LEVELS (JUMP_LEVELS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    assign m_err = m_tvalid && (m_tuser != tlde_pkg::ST_OK);

    `TLDE_ASSERT_RST(a_one_item, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "busy accept")
    `TLDE_ASSERT_RST(a_status_code, aclk, aresetn, m_tvalid |-> m_tuser <= tlde_pkg::ST_FULL, "bad status")
    `TLDE_ASSERT_RST(a_error_zero, aclk, aresetn, m_err |-> m_tdata == '0, "error result carries data")

endmodule
`default_nettype wire

@@ tb/tb_tree_lca_distance_engine.sv @@
// Self-checking testbench for the tree distance engine: random trees, adds and LCA queries.
`default_nettype none
module tb_tree_lca_distance_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES  = 65536;
    localparam int LEVELS = 16;
    localparam int STALL_LIMIT = 20000;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] first_node;
        logic [15:0] second_node;
        logic [31:0] edge_length;
    } tree_cmd_t;

    typedef struct packed {
        logic [47:0] path_length;
        logic [15:0] common_ancestor;
        logic [1:0]  status;
    } tree_answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0] m_tuser;

    tree_lca_distance_engine i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // shadow copy of the tree
    int unsigned  tree_size;
    logic [15:0]  node_depth [NODES];
    logic [47:0]  node_dist  [NODES];
    logic [15:0]  ancestor   [NODES][LEVELS];

    tree_cmd_t    pending_cmds[$];
    tree_answer_t awaited_answers[$];
    int errors = 0;
    int n_queries = 0, n_adds = 0, n_faults = 0;
    int idle_cycles = 0;
    bit stim_done = 0;
    bit drain_hold = 0;

    function automatic logic [15:0] climb(logic [15:0] v, int unsigned steps);
        while ((steps >> (LEVELS-1)) != 0) begin
            v = ancestor[v][LEVELS-1];
            steps -= 1 << (LEVELS-1);
        end
        for (int i = LEVELS-2; i >= 0; i--)
            if ((steps >> i) & 1) v = ancestor[v][i];
        return v;
    endfunction

    function automatic logic [15:0] common_root(logic [15:0] p, logic [15:0] q);
        logic [15:0] t;
        if (node_depth[p] < node_depth[q]) begin
            t = p; p = q; q = t;
        end
        p = climb(p, node_depth[p] - node_depth[q]);
        if (p == q) return p;
        while (ancestor[p][LEVELS-1] != ancestor[q][LEVELS-1]) begin
            p = ancestor[p][LEVELS-1];
            q = ancestor[q][LEVELS-1];
        end
        for (int i = LEVELS-2; i >= 0; i--)
            if (ancestor[p][i] != ancestor[q][i]) begin
                p = ancestor[p][i];
                q = ancestor[q][i];
            end
        return ancestor[p][0];
    endfunction

    function automatic void plant_root();
        tree_size = 1;
        node_depth[0] = '0;
        node_dist[0] = '0;
        for (int j = 0; j < LEVELS; j++) ancestor[0][j] = '0;
    endfunction

    function automatic tree_answer_t apply_cmd(tree_cmd_t c);
        tree_answer_t r;
        logic [48:0] sum;
        logic [15:0] l, v;
        r = '0;
        r.status = tlde_pkg::ST_OK;
        case (c.command)
            tlde_pkg::CMD_START: plant_root();
            tlde_pkg::CMD_ADD: begin
                if (tree_size >= NODES) r.status = tlde_pkg::ST_FULL;
                else if (c.first_node >= tree_size) r.status = tlde_pkg::ST_RANGE;
                else begin
                    v = tree_size[15:0];
                    sum = {1'b0, node_dist[c.first_node]} + c.edge_length;
                    node_depth[v] = node_depth[c.first_node] + 1;
                    node_dist[v] = sum[48] ? tlde_pkg::DIST_MAX : sum[47:0];
                    ancestor[v][0] = c.first_node;
                    for (int j = 1; j < LEVELS; j++)
                        ancestor[v][j] = ancestor[ancestor[v][j-1]][j-1];
                    tree_size++;
                    r.common_ancestor = v;
                end
            end
            tlde_pkg::CMD_QUERY: begin
                if (c.first_node >= tree_size || c.second_node >= tree_size)
                    r.status = tlde_pkg::ST_RANGE;
                else begin
                    l = common_root(c.first_node, c.second_node);
                    sum = {1'b0, node_dist[c.first_node] - node_dist[l]}
                        + (node_dist[c.second_node] - node_dist[l]);
                    r.path_length = sum[48] ? tlde_pkg::DIST_MAX : sum[47:0];
                    r.common_ancestor = l;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void push(logic [1:0] cmd, logic [15:0] a, logic [15:0] b,
                                 logic [31:0] len);
        tree_cmd_t c;
        c.command = cmd; c.first_node = a; c.second_node = b; c.edge_length = len;
        pending_cmds = {pending_cmds, c};
    endfunction

    initial begin
        forever #6 aclk = ~aclk;
    end

    // driver: bursts and gaps; predicts at acceptance
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                awaited_answers = {awaited_answers,
                                   apply_cmd({s_tuser, s_tdata[15:0],
                                              s_tdata[31:16], s_tdata[63:32]})};
                case (s_tuser)
                    tlde_pkg::CMD_ADD: n_adds++;
                    tlde_pkg::CMD_QUERY: n_queries++;
                    default: ;
                endcase
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0 && !drain_hold) begin
                    tree_cmd_t c;
                    c = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= c.command;
                    s_tdata <= {c.edge_length, c.second_node, c.first_node};
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end else s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall pattern
    int stall_phase = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                tree_answer_t want;
                if (awaited_answers.size() == 0) begin
                    $error("unexpected result item");
                    errors++;
                end else begin
                    want = awaited_answers.pop_front();
                    if (m_tdata[47:0] !== want.path_length) begin
                        $error("path_length exp %0d got %0d", want.path_length, m_tdata[47:0]);
                        errors++;
                    end
                    if (m_tdata[63:48] !== want.common_ancestor) begin
                        $error("common_ancestor exp %0d got %0d", want.common_ancestor,
                               m_tdata[63:48]);
                        errors++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status exp %0d got %0d", want.status, m_tuser);
                        errors++;
                    end
                    if (want.status != tlde_pkg::ST_OK) n_faults++;
                end
            end
            stall_phase = (stall_phase + 1) % 97;
            m_tready <= (stall_phase < 40) ? 1'b1 :
                        (stall_phase < 70) ? ($urandom_range(0, 2) != 0) :
                        ((stall_phase % 5) != 0);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // stimulus
    initial begin
        plant_root();
        // directed: root query, bad indices, unused command, max edge, long chain
        push(tlde_pkg::CMD_QUERY, 0, 0, 0);
        push(tlde_pkg::CMD_QUERY, 16'hFFFF, 0, 0);
        push(tlde_pkg::CMD_QUERY, 0, 16'hFFFF, 0);
        push(CMD_SPARE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        push(tlde_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 12; i++) push(tlde_pkg::CMD_ADD, i, $urandom, 32'hFFFF_FFFF);
        for (int i = 0; i < 4; i++) push(tlde_pkg::CMD_ADD, 0, 0, 32'hFFFF_FFFF);
        push(tlde_pkg::CMD_QUERY, 12, 16, 0);
        push(tlde_pkg::CMD_QUERY, 5, 0, 32'hFFFF_FFFF);
        push(tlde_pkg::CMD_QUERY, 13, 14, 0);
        push(tlde_pkg::CMD_ADD, 1, 0, 0);
        push(tlde_pkg::CMD_START, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        push(tlde_pkg::CMD_QUERY, 1, 0, 0);
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_cmds.size() == 0);
        drain_hold = 1;
        wait (awaited_answers.size() == 0);
        drain_hold = 0;

        // random: trees with chains and bushes, queries on existing nodes, bad indices, unused commands
        for (int t = 0; t < 10; t++) begin
            int unsigned nn;
            push(tlde_pkg::CMD_START, $urandom, $urandom, $urandom);
            nn = 1;
            for (int k = 0; k < 150; k++) begin
                int r;
                logic [31:0] len;
                r = $urandom_range(0, 99);
                len = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1000);
                if (r < 45) begin
                    logic [15:0] par;
                    par = ($urandom_range(0, 1) == 0) ? nn - 1 : $urandom_range(0, nn - 1);
                    push(tlde_pkg::CMD_ADD, par, $urandom, len);
                    nn++;
                end else if (r < 90)
                    push(tlde_pkg::CMD_QUERY, $urandom_range(0, nn - 1),
                         $urandom_range(0, nn - 1), $urandom);
                else if (r < 95)
                    push(tlde_pkg::CMD_QUERY, $urandom, $urandom, $urandom);
                else if (r < 98)
                    push(tlde_pkg::CMD_ADD, $urandom_range(nn, 65535), $urandom, $urandom);
                else
                    push(CMD_SPARE, $urandom, $urandom, $urandom);
            end
            if (t == 4) begin
                wait (pending_cmds.size() == 0);
                drain_hold = 1;
                wait (awaited_answers.size() == 0);
                drain_hold = 0;
            end
        end
        wait (pending_cmds.size() == 0);
        stim_done = 1;
    end

    // end of run
    initial begin
        wait (stim_done);
        while (s_tvalid || awaited_answers.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (awaited_answers.size() != 0) begin
            $error("%0d result items missing", awaited_answers.size());
            errors++;
        end
        $display("covered %0d adds, %0d queries, %0d error-status results",
                 n_adds, n_queries, n_faults);
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+design
design/tlde_pkg.sv
design/tlde_ctrl.sv
design/tlde_dp.sv
design/tree_lca_distance_engine.sv
tb/tb_tree_lca_distance_engine.sv
